>>> rtl/pal_pkg.sv
// pal_pkg: shared types and constants for the positional array list
// holds command and status codes, channel structs, controller states and control structs
// no dependencies
package pal_pkg;

  localparam int CAPACITY    = 256;
  localparam int DATA_WIDTH  = 32;
  localparam int POS_W       = 8;
  localparam int VAL_W       = 32;
  localparam int CNT_FIELD_W = 9;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_ERASE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0]       read_value;
    logic [1:0]             status;
    logic [CNT_FIELD_W-1:0] count;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd_pos;
    logic put;
    logic shift;
    logic drain;
    logic result;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic err;
    logic noshift;
    logic last;
  } sts_t;

endpackage

>>> rtl/pal_ram.sv
// pal_ram: generic single write port, single read port memory with registered read
// no dependencies
module pal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/pal_ctrl.sv
// pal_ctrl: controller state machine sequencing one command at a time
// depends on pal_pkg (states, control and status structs)
module pal_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pal_pkg::sts_t sts,
  output pal_pkg::ctl_t ctl
);

  pal_pkg::state_t state_r;
  pal_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pal_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pal_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = pal_pkg::S_EXEC;
        end
      end
      pal_pkg::S_EXEC: begin
        if (sts.err || sts.noshift ||
            sts.cmd == pal_pkg::CMD_READ || sts.cmd == pal_pkg::CMD_WRITE) begin
          state_nxt = pal_pkg::S_RESULT;
        end else begin
          state_nxt = pal_pkg::S_SHIFT;
        end
      end
      pal_pkg::S_SHIFT: begin
        if (sts.last) begin
          state_nxt = pal_pkg::S_DRAIN;
        end
      end
      pal_pkg::S_DRAIN: begin
        if (sts.cmd == pal_pkg::CMD_INSERT) begin
          state_nxt = pal_pkg::S_PUT;
        end else begin
          state_nxt = pal_pkg::S_RESULT;
        end
      end
      pal_pkg::S_PUT:    state_nxt = pal_pkg::S_RESULT;
      pal_pkg::S_RESULT: state_nxt = pal_pkg::S_IDLE;
      default:           state_nxt = pal_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state_r)
      pal_pkg::S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      pal_pkg::S_EXEC: begin
        ctl.exec   = 1'b1;
        ctl.rd_pos = !sts.err && sts.cmd == pal_pkg::CMD_READ;
        ctl.put    = !sts.err && (sts.cmd == pal_pkg::CMD_WRITE ||
                     (sts.cmd == pal_pkg::CMD_INSERT && sts.noshift));
      end
      pal_pkg::S_SHIFT:  ctl.shift  = 1'b1;
      pal_pkg::S_DRAIN:  ctl.drain  = 1'b1;
      pal_pkg::S_PUT:    ctl.put    = 1'b1;
      pal_pkg::S_RESULT: ctl.result = 1'b1;
      default:           busy       = 1'b1;
    endcase
  end

endmodule

>>> rtl/pal_dp.sv
// pal_dp: datapath with element memory, element count, shift pointers and result register
// depends on pal_pkg and pal_ram
module pal_dp #(
  parameter int CAPACITY   = pal_pkg::CAPACITY,
  parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pal_pkg::in_t  in_data,
  input  pal_pkg::ctl_t ctl,
  output pal_pkg::sts_t sts,
  output logic          out_valid,
  output pal_pkg::out_t out_data
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > pal_pkg::CNT_FIELD_W) ? CW : pal_pkg::CNT_FIELD_W;
  localparam int MW   = (DATA_WIDTH > pal_pkg::VAL_W) ? DATA_WIDTH : pal_pkg::VAL_W;

  pal_pkg::cmd_t               cmd_r,       cmd_nxt;
  logic [pal_pkg::POS_W-1:0]   pos_r,       pos_nxt;
  logic [pal_pkg::VAL_W-1:0]   val_r,       val_nxt;
  logic [CW-1:0]               count_r,     count_nxt;
  logic [AW-1:0]               rd_ptr_r,    rd_ptr_nxt;
  logic [AW-1:0]               end_r,       end_nxt;
  logic [AW-1:0]               wr_ptr_r,    wr_ptr_nxt;
  logic                        pend_r,      pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  pal_pkg::out_t               out_data_r,  out_data_nxt;

  logic [CMPW-1:0]       pos_ext, cnt_ext, cnt_m1, pos_p1, cnt_new_ext;
  logic [AW-1:0]         pos_a;
  logic [CW-1:0]         cnt_new;
  pal_pkg::status_t      st;
  logic                  is_ins;
  logic [MW-1:0]         val_w, rd_w;
  logic [DATA_WIDTH-1:0] val_d;

  logic                  ram_wr_en, ram_rd_en;
  logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
  logic [DATA_WIDTH-1:0] ram_wr_data, ram_rd_data;

  pal_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    pos_r      <= pos_nxt;
    val_r      <= val_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    end_r      <= end_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    out_data_r <= out_data_nxt;
  end

  // range and capacity checks on the captured command
  always_comb begin
    pos_ext = CMPW'(pos_r);
    cnt_ext = CMPW'(count_r);
    cnt_m1  = cnt_ext - CMPW'(1);
    pos_p1  = pos_ext + CMPW'(1);
    pos_a   = pos_ext[AW-1:0];
    is_ins  = (cmd_r == pal_pkg::CMD_INSERT);
    if (is_ins) begin
      if (pos_ext > cnt_ext) begin
        st = pal_pkg::ST_RANGE;
      end else if (count_r == CW'(CAPACITY)) begin
        st = pal_pkg::ST_FULL;
      end else begin
        st = pal_pkg::ST_OK;
      end
    end else begin
      st = (pos_ext >= cnt_ext) ? pal_pkg::ST_RANGE : pal_pkg::ST_OK;
    end
    sts.cmd     = cmd_r;
    sts.err     = (st != pal_pkg::ST_OK);
    sts.noshift = is_ins ? (pos_ext == cnt_ext) : (pos_p1 == cnt_ext);
    sts.last    = (rd_ptr_r == end_r);
  end

  always_comb begin
    val_w = MW'(val_r);
    val_d = val_w[DATA_WIDTH-1:0];
    rd_w  = MW'(ram_rd_data);

    ram_rd_en   = ctl.rd_pos | ctl.shift;
    ram_rd_addr = ctl.shift ? rd_ptr_r : pos_a;
    ram_wr_en   = ctl.put | ((ctl.shift | ctl.drain) & pend_r);
    ram_wr_addr = ctl.put ? pos_a : wr_ptr_r;
    ram_wr_data = ctl.put ? val_d : ram_rd_data;
  end

  always_comb begin
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    end_nxt       = end_r;
    wr_ptr_nxt    = wr_ptr_r;
    pend_nxt      = ctl.shift;
    out_valid_nxt = ctl.result;
    out_data_nxt  = out_data_r;
    cnt_new       = count_r;

    if (ctl.load) begin
      cmd_nxt = pal_pkg::cmd_t'(in_data.command);
      pos_nxt = in_data.position;
      val_nxt = in_data.value;
    end

    // first and last read address of the shift sweep
    if (ctl.exec) begin
      rd_ptr_nxt = is_ins ? cnt_m1[AW-1:0] : pos_p1[AW-1:0];
      end_nxt    = is_ins ? pos_a : cnt_m1[AW-1:0];
    end

    if (ctl.shift) begin
      rd_ptr_nxt = is_ins ? rd_ptr_r - AW'(1) : rd_ptr_r + AW'(1);
      wr_ptr_nxt = is_ins ? rd_ptr_r + AW'(1) : rd_ptr_r - AW'(1);
    end

    if (!sts.err) begin
      case (cmd_r)
        pal_pkg::CMD_INSERT: cnt_new = count_r + CW'(1);
        pal_pkg::CMD_ERASE:  cnt_new = count_r - CW'(1);
        default:             cnt_new = count_r;
      endcase
    end
    cnt_new_ext = CMPW'(cnt_new);

    if (ctl.result) begin
      count_nxt               = cnt_new;
      out_data_nxt.read_value = (!sts.err && cmd_r == pal_pkg::CMD_READ) ?
                                rd_w[pal_pkg::VAL_W-1:0] : '0;
      out_data_nxt.status     = st;
      out_data_nxt.count      = cnt_new_ext[pal_pkg::CNT_FIELD_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/positional_array_list_top.sv
// positional_array_list_top: fixed-capacity ordered list with read, overwrite, insert, erase
// depends on pal_pkg, pal_ctrl, pal_dp (which holds pal_ram)
//
//  channel  ports                   flow control
//  in       start, busy, in_data    taken when start is high and busy is low
//  out      out_valid, out_data     one-cycle strobe, always taken
//
// read, overwrite and any rejected command: busy through EXEC and RESULT
// insert shifting n = count - position elements: EXEC, SHIFT, DRAIN, PUT, RESULT
// erase shifting n = count - 1 - position elements: EXEC, SHIFT, DRAIN, RESULT
// with n = 0 both go straight from EXEC to RESULT; one memory write per shifted element
// busy drops in the strobe cycle; reset clears the count, memory contents are undefined
module positional_array_list_top #(
  parameter int CAPACITY   = pal_pkg::CAPACITY,
  parameter int DATA_WIDTH = pal_pkg::DATA_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pal_pkg::in_t  in_data,
  output logic          out_valid,
  output pal_pkg::out_t out_data
);

  pal_pkg::ctl_t ctl;
  pal_pkg::sts_t sts;

  pal_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  pal_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
